// ===== rtl/rhc_pkg.sv =====
package rhc_pkg;

    // field widths
    localparam int COMP_W = 8;
    localparam int HUE_W  = 13;

    // fixed-point hue scaling, sixteenths of a degree
    localparam int SECTOR_UNITS = 960;
    localparam int FULL_CIRCLE  = 6 * SECTOR_UNITS;

    // divider sizing: numerators below 2**QUO_W times the divisor
    localparam int QUO_W = 10;
    localparam int NUM_W = COMP_W + QUO_W;

    // signed working width for the hue sum
    localparam int HSUM_W = 14;

    // default depth of the queue between classifier and divider pipe
    localparam int QUEUE_DEPTH = 4;

    // which component holds the maximum
    typedef enum logic [1:0] {
        SECT_RED   = 2'd0,
        SECT_GREEN = 2'd1,
        SECT_BLUE  = 2'd2
    } sector_t;

    // classified pixel, ready for division
    typedef struct packed {
        logic [NUM_W-1:0]  hue_num;
        logic [NUM_W-1:0]  sat_num;
        logic [COMP_W-1:0] delta;
        logic [COMP_W-1:0] bright;
        logic              hue_neg;
        sector_t           sector;
    } item_t;

endpackage

// ===== rtl/rhc_ifs.sv =====
interface rgb_if;
    logic                      valid;
    logic                      ready;
    logic [rhc_pkg::COMP_W-1:0] red_in;
    logic [rhc_pkg::COMP_W-1:0] green_in;
    logic [rhc_pkg::COMP_W-1:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

interface hsv_if;
    logic                      valid;
    logic                      ready;
    logic [rhc_pkg::HUE_W-1:0]  hue_out;
    logic [rhc_pkg::COMP_W-1:0] sat_out;
    logic [rhc_pkg::COMP_W-1:0] bright_out;

    modport source (output valid, output hue_out, output sat_out, output bright_out,
                    input ready);
    modport sink   (input valid, input hue_out, input sat_out, input bright_out,
                    output ready);
endinterface

// ===== rtl/rhc_front.sv =====
module rhc_front
(
    rgb_if.sink              pixel,
    input  logic             q_ready,
    output logic             push,
    output rhc_pkg::item_t   item
);

    logic [rhc_pkg::COMP_W-1:0] mx;
    logic [rhc_pkg::COMP_W-1:0] mn;
    logic [rhc_pkg::COMP_W-1:0] delta;
    logic [rhc_pkg::COMP_W:0]   minuend;
    logic [rhc_pkg::COMP_W:0]   subtrahend;
    logic signed [rhc_pkg::COMP_W:0] diff;
    logic [rhc_pkg::COMP_W-1:0] mag;
    rhc_pkg::sector_t           sector;

    // transfer whenever the queue has room
    assign pixel.ready = q_ready;
    assign push        = pixel.valid && q_ready;

    // max, min and winning component, ties to red then green
    always_comb
    begin
        mx = pixel.red_in;
        mn = pixel.red_in;
        if (pixel.green_in > mx) mx = pixel.green_in;
        if (pixel.blue_in > mx)  mx = pixel.blue_in;
        if (pixel.green_in < mn) mn = pixel.green_in;
        if (pixel.blue_in < mn)  mn = pixel.blue_in;
        delta = mx - mn;

        if (pixel.red_in >= pixel.green_in && pixel.red_in >= pixel.blue_in)
        begin
            sector     = rhc_pkg::SECT_RED;
            minuend    = {1'b0, pixel.green_in};
            subtrahend = {1'b0, pixel.blue_in};
        end
        else if (pixel.green_in >= pixel.blue_in)
        begin
            sector     = rhc_pkg::SECT_GREEN;
            minuend    = {1'b0, pixel.blue_in};
            subtrahend = {1'b0, pixel.red_in};
        end
        else
        begin
            sector     = rhc_pkg::SECT_BLUE;
            minuend    = {1'b0, pixel.red_in};
            subtrahend = {1'b0, pixel.green_in};
        end
    end

    // signed spread inside the sector, split into sign and magnitude
    always_comb
    begin
        diff = signed'(minuend - subtrahend);
        mag  = diff[rhc_pkg::COMP_W] ? rhc_pkg::COMP_W'(-diff) : diff[rhc_pkg::COMP_W-1:0];
    end

    // numerators: 960 * mag and 255 * delta, built from shifts
    always_comb
    begin
        item.hue_num = (rhc_pkg::NUM_W'(mag) << 10) - (rhc_pkg::NUM_W'(mag) << 6);
        item.sat_num = (rhc_pkg::NUM_W'(delta) << 8) - rhc_pkg::NUM_W'(delta);
        item.delta   = delta;
        item.bright  = mx;
        item.hue_neg = diff[rhc_pkg::COMP_W];
        item.sector  = sector;
    end

endmodule

// ===== rtl/rhc_fifo.sv =====
module rhc_fifo
#(
    parameter int Depth = rhc_pkg::QUEUE_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rhc_pkg::item_t push_item,
    output logic           push_ready,
    input  logic           pop,
    output logic           pop_valid,
    output rhc_pkg::item_t pop_item
);

    localparam int PtrW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);

    rhc_pkg::item_t mem_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign push_ready = count_reg != CntW'(Depth);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    // no write into a full queue, no read from an empty one
    assert property (@(posedge clk) disable iff (!rst_n) push |-> push_ready)
        else $error("queue written while full");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> pop_valid)
        else $error("queue read while empty");
    assert property (@(posedge clk) disable iff (!rst_n)
                     (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("fill count lost a write");

endmodule

// ===== rtl/rhc_back.sv =====
module rhc_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  rhc_pkg::item_t q_item,
    output logic           q_pop,
    hsv_if.source          hsv
);

    localparam int Ns = rhc_pkg::QUO_W;

    logic                        stage_valid_reg [Ns+1];
    logic [rhc_pkg::NUM_W-1:0]   hue_rem_reg     [Ns+1];
    logic [rhc_pkg::NUM_W-1:0]   sat_rem_reg     [Ns+1];
    logic [rhc_pkg::QUO_W-1:0]   hue_quo_reg     [Ns+1];
    logic [rhc_pkg::QUO_W-1:0]   sat_quo_reg     [Ns+1];
    logic [rhc_pkg::COMP_W-1:0]  delta_reg       [Ns+1];
    logic [rhc_pkg::COMP_W-1:0]  bright_reg      [Ns+1];
    logic                        neg_reg         [Ns+1];
    rhc_pkg::sector_t            sector_reg      [Ns+1];

    logic                        out_valid_reg;
    logic [rhc_pkg::HUE_W-1:0]   hue_reg, hue_next;
    logic [rhc_pkg::COMP_W-1:0]  sat_reg, sat_next;
    logic [rhc_pkg::COMP_W-1:0]  bright_out_reg;

    logic                        advance;

    // whole pipe moves when the output register is free or being taken
    assign advance = !out_valid_reg || hsv.ready;
    assign q_pop   = advance && q_valid;

    // entry stage loads the classified pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg[0] <= 1'b0;
        else if (advance)
            stage_valid_reg[0] <= q_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hue_rem_reg[0] <= q_item.hue_num;
            sat_rem_reg[0] <= q_item.sat_num;
            hue_quo_reg[0] <= '0;
            sat_quo_reg[0] <= '0;
            delta_reg[0]   <= q_item.delta;
            bright_reg[0]  <= q_item.bright;
            neg_reg[0]     <= q_item.hue_neg;
            sector_reg[0]  <= q_item.sector;
        end
    end

    // restoring divider, one quotient bit per stage, two lanes side by side
    for (genvar k = 0; k < Ns; k++)
    begin : g_div
        localparam int Sh = rhc_pkg::QUO_W - 1 - k;

        logic [rhc_pkg::NUM_W-1:0] hue_dvs;
        logic [rhc_pkg::NUM_W-1:0] sat_dvs;
        logic                      hue_ge;
        logic                      sat_ge;

        always_comb
        begin
            hue_dvs = rhc_pkg::NUM_W'(delta_reg[k]) << Sh;
            sat_dvs = rhc_pkg::NUM_W'(bright_reg[k]) << Sh;
            hue_ge  = hue_rem_reg[k] >= hue_dvs;
            sat_ge  = sat_rem_reg[k] >= sat_dvs;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                stage_valid_reg[k+1] <= 1'b0;
            else if (advance)
                stage_valid_reg[k+1] <= stage_valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                hue_rem_reg[k+1] <= hue_ge ? hue_rem_reg[k] - hue_dvs : hue_rem_reg[k];
                sat_rem_reg[k+1] <= sat_ge ? sat_rem_reg[k] - sat_dvs : sat_rem_reg[k];
                hue_quo_reg[k+1] <= {hue_quo_reg[k][rhc_pkg::QUO_W-2:0], hue_ge};
                sat_quo_reg[k+1] <= {sat_quo_reg[k][rhc_pkg::QUO_W-2:0], sat_ge};
                delta_reg[k+1]   <= delta_reg[k];
                bright_reg[k+1]  <= bright_reg[k];
                neg_reg[k+1]     <= neg_reg[k];
                sector_reg[k+1]  <= sector_reg[k];
            end
        end
    end

    // floor for negative offsets, sector base, wrap into one turn
    logic [rhc_pkg::QUO_W:0]           off_mag;
    logic signed [rhc_pkg::HSUM_W-1:0] off_s;
    logic signed [rhc_pkg::HSUM_W-1:0] base_s;
    logic signed [rhc_pkg::HSUM_W-1:0] sum_s;
    logic signed [rhc_pkg::HSUM_W-1:0] wrap_s;

    always_comb
    begin
        off_mag = {1'b0, hue_quo_reg[Ns]}
                + (rhc_pkg::QUO_W + 1)'(neg_reg[Ns] && (hue_rem_reg[Ns] != '0));
        off_s   = neg_reg[Ns] ? -signed'(rhc_pkg::HSUM_W'(off_mag))
                              : signed'(rhc_pkg::HSUM_W'(off_mag));
        unique case (sector_reg[Ns])
            rhc_pkg::SECT_RED:   base_s = '0;
            rhc_pkg::SECT_GREEN: base_s = rhc_pkg::HSUM_W'(2 * rhc_pkg::SECTOR_UNITS);
            rhc_pkg::SECT_BLUE:  base_s = rhc_pkg::HSUM_W'(4 * rhc_pkg::SECTOR_UNITS);
            default:             base_s = '0;
        endcase
        sum_s  = base_s + off_s;
        wrap_s = (sum_s < 0) ? sum_s + rhc_pkg::HSUM_W'(rhc_pkg::FULL_CIRCLE) : sum_s;

        // grey pixel: no hue; black pixel: no saturation
        hue_next = (delta_reg[Ns] == '0) ? '0 : wrap_s[rhc_pkg::HUE_W-1:0];
        sat_next = (bright_reg[Ns] == '0) ? '0 : sat_quo_reg[Ns][rhc_pkg::COMP_W-1:0];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= stage_valid_reg[Ns];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hue_reg        <= hue_next;
            sat_reg        <= sat_next;
            bright_out_reg <= bright_reg[Ns];
        end
    end

    assign hsv.valid      = out_valid_reg;
    assign hsv.hue_out    = hue_reg;
    assign hsv.sat_out    = sat_reg;
    assign hsv.bright_out = bright_out_reg;

    // a held result keeps the queue from draining into the pipe
    assert property (@(posedge clk) disable iff (!rst_n)
                     (hsv.valid && !hsv.ready) |-> !q_pop)
        else $error("queue popped while output stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
                     hsv.valid |-> hsv.hue_out < rhc_pkg::HUE_W'(rhc_pkg::FULL_CIRCLE))
        else $error("hue outside one turn");
    assert property (@(posedge clk) disable iff (!rst_n)
                     (hsv.valid && hsv.bright_out == '0) |-> (hsv.sat_out == '0 &&
                                                               hsv.hue_out == '0))
        else $error("black pixel with hue or saturation");
    assert property (@(posedge clk) disable iff (!rst_n)
                     (hsv.valid && hsv.sat_out == '0) |-> hsv.hue_out == '0)
        else $error("grey pixel with nonzero hue");

endmodule

// ===== rtl/rgb_to_hsv_converter.sv =====
// channel  dir  fields                            width
// -------  ---  --------------------------------  ---------
// pixel    in   red_in, green_in, blue_in         8, 8, 8
// hsv      out  hue_out, sat_out, bright_out      13, 8, 8
//
// one pixel per clock sustained while the output is not stalled
// path: queue write, entry stage, 10 restoring divider stages, output register
// rst_n clears queue count and stage valid bits; no clearing pass
// a stalled output freezes the divider pipe; the queue keeps taking pixels until full
module rgb_to_hsv_converter
#(
    parameter int QueueDepth = rhc_pkg::QUEUE_DEPTH
)
(
    input  logic  clk,
    input  logic  rst_n,
    rgb_if.sink   pixel,
    hsv_if.source hsv
);

    logic           push;
    logic           push_ready;
    logic           pop;
    logic           pop_valid;
    rhc_pkg::item_t push_item;
    rhc_pkg::item_t pop_item;

    // classifier
    rhc_front u_front
    (
        .pixel   (pixel),
        .q_ready (push_ready),
        .push    (push),
        .item    (push_item)
    );

    // decoupling queue
    rhc_fifo #(.Depth(QueueDepth)) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item)
    );

    // divider pipe and output register
    rhc_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (pop_valid),
        .q_item  (pop_item),
        .q_pop   (pop),
        .hsv     (hsv)
    );

endmodule
